// File: sv/dtfp_pkg.sv
// Shared types, status codes and the 10^-k fraction table for the decimal text parser.
package dtfp_pkg;

	localparam int CHAR_W     = 8;
	localparam int VALUE_W    = 64;
	localparam int STATUS_W   = 2;
	localparam int FRAC_ACC_W = 32;
	localparam int DIGIT_W    = 4;
	localparam int CNT_W      = 4;
	localparam int S_TDATA_W  = 8;
	localparam int M_TDATA_W  = 72;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd2;

	typedef struct packed {
		logic [VALUE_W-1:0]  mag;
		logic                negative;
		logic [STATUS_W-1:0] status;
	} result_t;

	// 10^-(idx+1) in Q0.32, rounded to nearest
	function automatic logic [FRAC_ACC_W-1:0] pow10_neg(input logic [CNT_W-1:0] idx);
		logic [FRAC_ACC_W-1:0] r;
		case (idx)
			4'd0:    r = 32'd429496730;
			4'd1:    r = 32'd42949673;
			4'd2:    r = 32'd4294967;
			4'd3:    r = 32'd429497;
			4'd4:    r = 32'd42950;
			4'd5:    r = 32'd4295;
			4'd6:    r = 32'd429;
			4'd7:    r = 32'd43;
			4'd8:    r = 32'd4;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

// File: sv/dtfp_accum.sv
// Character classifier, parse state machine and integer/fraction accumulators.
module dtfp_accum #(
	parameter int INT_BITS    = 31,
	parameter int FRAC_BITS   = 32,
	parameter int FRAC_DIGITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [dtfp_pkg::CHAR_W-1:0]   char_code,
	output dtfp_pkg::result_t             result
);

	localparam logic [2:0] PH_BLANK = 3'd0;
	localparam logic [2:0] PH_SIGN  = 3'd1;
	localparam logic [2:0] PH_INT   = 3'd2;
	localparam logic [2:0] PH_FRAC  = 3'd3;
	localparam logic [2:0] PH_BAD   = 3'd4;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;

	localparam int WW = INT_BITS + 4;
	localparam int FW = dtfp_pkg::FRAC_ACC_W;
	localparam int PW = FW + dtfp_pkg::DIGIT_W;
	localparam logic [dtfp_pkg::CNT_W-1:0] CNT_MAX = '1;
	localparam logic [dtfp_pkg::CNT_W-1:0] DIG_LIM = dtfp_pkg::CNT_W'(FRAC_DIGITS);

	logic [2:0]                      phase_q, phase_d;
	logic                            neg_q, neg_d;
	logic [INT_BITS-1:0]             whole_q, whole_d;
	logic [FW-1:0]                   frac_q, frac_d;
	logic [dtfp_pkg::CNT_W-1:0]      cnt_q, cnt_d;
	logic                            ovf_q, ovf_d;

	logic                            is_nul, is_digit, is_blank, is_sign, is_dot, is_minus;
	logic [dtfp_pkg::DIGIT_W-1:0]    digit;
	logic [WW-1:0]                   w_ext, w_mul;
	logic                            w_sat;
	logic [INT_BITS-1:0]             whole_add;
	logic [dtfp_pkg::CNT_W-1:0]      cnt_inc;
	logic [PW-1:0]                   prod;
	logic [PW:0]                     fsum;
	logic [FW-1:0]                   frac_add;
	logic                            frac_use;
	logic [dtfp_pkg::VALUE_W-1:0]    whole_ext;

	assign is_nul   = (char_code == '0);
	assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign is_blank = (char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR));
	assign is_minus = (char_code == CH_MINUS);
	assign is_sign  = is_minus || (char_code == CH_PLUS);
	assign is_dot   = (char_code == CH_DOT);
	assign digit    = dtfp_pkg::DIGIT_W'(char_code - CH_ZERO);

	// whole * 10 + digit, saturating at 2^INT_BITS - 1
	assign w_ext     = WW'(whole_q);
	assign w_mul     = (w_ext << 3) + (w_ext << 1) + WW'(digit);
	assign w_sat     = |w_mul[WW-1:INT_BITS];
	assign whole_add = w_sat ? '1 : w_mul[INT_BITS-1:0];

	// fraction digit k adds digit * 10^-k while k does not exceed FRAC_DIGITS
	assign cnt_inc  = (cnt_q == CNT_MAX) ? CNT_MAX : cnt_q + 1'b1;
	assign frac_use = (cnt_inc <= DIG_LIM);
	assign prod     = PW'(digit) * PW'(dtfp_pkg::pow10_neg(cnt_inc - 1'b1));
	assign fsum     = (PW + 1)'(frac_q) + (PW + 1)'(prod);
	assign frac_add = (|fsum[PW:FW]) ? '1 : fsum[FW-1:0];

	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		whole_d = whole_q;
		frac_d  = frac_q;
		cnt_d   = cnt_q;
		ovf_d   = ovf_q;
		if (is_nul) begin
			phase_d = PH_BLANK;
			neg_d   = 1'b0;
			whole_d = '0;
			frac_d  = '0;
			cnt_d   = '0;
			ovf_d   = 1'b0;
		end else begin
			unique case (phase_q)
				PH_BLANK, PH_SIGN: begin
					if (is_blank && phase_q == PH_BLANK) begin
						phase_d = PH_BLANK;
					end else if (is_sign) begin
						if (is_minus) neg_d = 1'b1;
						phase_d = PH_SIGN;
					end else if (is_digit) begin
						whole_d = whole_add;
						ovf_d   = ovf_q | w_sat;
						phase_d = PH_INT;
					end else if (is_dot) begin
						phase_d = PH_FRAC;
					end else begin
						phase_d = PH_BAD;
					end
				end
				PH_INT: begin
					if (is_digit) begin
						whole_d = whole_add;
						ovf_d   = ovf_q | w_sat;
					end else if (is_dot) begin
						phase_d = PH_FRAC;
					end else begin
						phase_d = PH_BAD;
					end
				end
				PH_FRAC: begin
					if (is_digit) begin
						cnt_d = cnt_inc;
						if (frac_use) frac_d = frac_add;
					end else begin
						phase_d = PH_BAD;
					end
				end
				default: phase_d = PH_BAD;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BLANK;
			neg_q   <= 1'b0;
			whole_q <= '0;
			frac_q  <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			neg_q   <= neg_d;
			whole_q <= whole_d;
			frac_q  <= frac_d;
			cnt_q   <= cnt_d;
			ovf_q   <= ovf_d;
		end
	end

	// magnitude as seen by a terminating NUL
	assign whole_ext = dtfp_pkg::VALUE_W'(whole_q);

	always_comb begin
		if (phase_q >= PH_BAD) begin
			result.mag      = '0;
			result.negative = 1'b0;
			result.status   = dtfp_pkg::ST_INVALID;
		end else begin
			result.mag      = (whole_ext << FRAC_BITS) |
				dtfp_pkg::VALUE_W'(frac_q >> (FW - FRAC_BITS));
			result.negative = neg_q;
			result.status   = ovf_q ? dtfp_pkg::ST_SATURATED : dtfp_pkg::ST_OK;
		end
	end

endmodule

// File: sv/dtfp_out_reg.sv
// Result register: applies the sign and holds one result until the master side takes it.
module dtfp_out_reg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	input  dtfp_pkg::result_t                result,
	input  logic                             m_tready,
	output logic                             m_tvalid,
	output logic [dtfp_pkg::M_TDATA_W-1:0]   m_tdata
);

	localparam int PAD_W = dtfp_pkg::M_TDATA_W - dtfp_pkg::VALUE_W - dtfp_pkg::STATUS_W;

	logic                             valid_q;
	logic [dtfp_pkg::VALUE_W-1:0]     value_q;
	logic [dtfp_pkg::STATUS_W-1:0]    status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q  <= result.negative ? (~result.mag + 1'b1) : result.mag;
			status_q <= result.status;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, status_q, value_q};

endmodule

// File: sv/decimal_text_to_fixed_parser.sv
// Top level: input register, parse/accumulate stage and result register.
// A NUL waits in the input register until the result register loads its result for m_tvalid.
// Throughput: one character per cycle; the accumulator update is one shift-add and one
// 4 x 32 table multiply between the input register and the state registers.
// Input stalls only while a NUL waits behind an untaken result.
// Reset (arst_n low, asynchronous) empties both registers and returns to blank skipping.
module decimal_text_to_fixed_parser #(
	parameter int FRAC_BITS   = 32,
	parameter int INT_BITS    = 31,
	parameter int FRAC_DIGITS = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [dtfp_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] char_code
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [dtfp_pkg::M_TDATA_W-1:0]   m_tdata    // [63:0] value, [65:64] status, rest 0
);

	logic                           valid_s1;
	logic [dtfp_pkg::CHAR_W-1:0]    char_s1;
	logic                           nul_s1;
	logic                           adv_s1;
	logic                           load;
	dtfp_pkg::result_t              result;

	assign nul_s1   = (char_s1 == '0);
	// a NUL may only advance when the result register is free or being drained
	assign adv_s1   = valid_s1 && (!nul_s1 || !m_tvalid || m_tready);
	assign load     = adv_s1 && nul_s1;
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata[dtfp_pkg::CHAR_W-1:0];
		end
	end

	dtfp_accum #(
		.INT_BITS   (INT_BITS),
		.FRAC_BITS  (FRAC_BITS),
		.FRAC_DIGITS(FRAC_DIGITS)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv_s1),
		.char_code(char_s1),
		.result   (result)
	);

	dtfp_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.result  (result),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.m_tdata (m_tdata)
	);

	a_stall_only_on_nul: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && nul_s1 && m_tvalid && !m_tready))
		else $error("input stalled without a pending NUL behind a held result");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> m_tvalid)
		else $error("loaded result not presented");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[65:64] == dtfp_pkg::ST_OK ||
			m_tdata[65:64] == dtfp_pkg::ST_INVALID ||
			m_tdata[65:64] == dtfp_pkg::ST_SATURATED))
		else $error("undefined status code");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[65:64] == dtfp_pkg::ST_INVALID) |-> (m_tdata[63:0] == '0))
		else $error("invalid text must give zero value");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!m_tvalid || m_tready))
		else $error("result register overwritten before transfer");

endmodule
